// ===== sv/speq_pkg.sv =====
`timescale 1ns / 1ps

package speq_pkg;

   localparam logic ACT_PUSH = 1'b0;
   localparam logic ACT_POP  = 1'b1;

   localparam logic [1:0] RC_OK    = 2'd0;
   localparam logic [1:0] RC_EMPTY = 2'd1;
   localparam logic [1:0] RC_FULL  = 2'd2;

   localparam int OCC_W = 5;

   typedef struct packed {
      logic [7:0]         prio;
      logic [3:0]         sys;
      logic [3:0]         res;
      logic [7:0]         stat;
      logic signed [15:0] amt;
   } event_type;

   typedef struct packed {
      logic       load;
      logic       push;
      logic       pop;
      logic [1:0] code;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } status_type;

endpackage

// ===== sv/speq_ctrl.sv =====
`timescale 1ns / 1ps

module speq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_action,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  speq_pkg::status_type status,
   output speq_pkg::cmd_type    cmd
);

   typedef enum logic {ST_EMPTY, ST_HOLD} state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_stall = (state_ff == ST_HOLD) && rsp_stall;
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_HOLD);

   always_comb begin
      cmd.load = accept;
      cmd.push = accept && (req_action == speq_pkg::ACT_PUSH) && !status.full;
      cmd.pop  = accept && (req_action == speq_pkg::ACT_POP) && !status.empty;
      if (req_action == speq_pkg::ACT_PUSH) begin
         cmd.code = status.full ? speq_pkg::RC_FULL : speq_pkg::RC_OK;
      end else begin
         cmd.code = status.empty ? speq_pkg::RC_EMPTY : speq_pkg::RC_OK;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_EMPTY: begin
            if (accept) state_in = ST_HOLD;
         end
         ST_HOLD: begin
            if (accept) state_in = ST_HOLD;
            else if (!rsp_stall) state_in = ST_EMPTY;
         end
         default: state_in = ST_EMPTY;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_EMPTY;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/speq_dp.sv =====
`timescale 1ns / 1ps

module speq_dp #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  speq_pkg::cmd_type                   cmd,
   output speq_pkg::status_type                status,
   input  speq_pkg::event_type                 req_event,
   output speq_pkg::event_type                 rsp_event,
   output logic [1:0]                          rsp_code,
   output logic [speq_pkg::OCC_W-1:0]          rsp_occupancy
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   speq_pkg::event_type entry_ff [QUEUE_DEPTH];
   speq_pkg::event_type entry_in [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] ahead;
   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW+speq_pkg::OCC_W-1:0] count_ext;

   speq_pkg::event_type rsp_event_ff;
   logic [1:0] rsp_code_ff;
   logic [speq_pkg::OCC_W-1:0] rsp_occupancy_ff;

   assign status.full  = (count_ff == CW'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

   // Each cell compares itself with the new word; held cells form a sorted prefix.
   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         ahead[i] = (CW'(i) < count_ff) && (entry_ff[i].prio >= req_event.prio);
      end
   end

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         entry_in[i] = entry_ff[i];
         if (cmd.push) begin
            if (ahead[i]) begin
               entry_in[i] = entry_ff[i];
            end else if (i == 0) begin
               entry_in[i] = req_event;
            end else if (ahead[i-1]) begin
               entry_in[i] = req_event;
            end else begin
               entry_in[i] = entry_ff[i-1];
            end
         end else if (cmd.pop && (i < QUEUE_DEPTH - 1)) begin
            entry_in[i] = entry_ff[i+1];
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.push) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign count_ext = {{speq_pkg::OCC_W{1'b0}}, count_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         entry_ff[i] <= entry_in[i];
      end
      if (cmd.load) begin
         rsp_event_ff     <= cmd.pop ? entry_ff[0] : '0;
         rsp_code_ff      <= cmd.code;
         rsp_occupancy_ff <= count_ext[speq_pkg::OCC_W-1:0];
      end
   end

   assign rsp_event     = rsp_event_ff;
   assign rsp_code      = rsp_code_ff;
   assign rsp_occupancy = rsp_occupancy_ff;

endmodule

// ===== sv/stable_priority_event_queue_core.sv =====
// Latency: a result word is valid in the cycle after its request word is accepted.
// Throughput: one push or pop per cycle while the result side does not stall; the
// row of sorted cells, all updated together for each accepted word, sets this figure.
// Reset (synchronous, active high) empties the queue and drops any held result;
// the cells themselves are not cleared.
`timescale 1ns / 1ps

module stable_priority_event_queue_core #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_action,
   input  logic [7:0]         req_priority_req,
   input  logic [3:0]         req_system_id,
   input  logic [3:0]         req_resource_id,
   input  logic [7:0]         req_event_status,
   input  logic signed [15:0] req_amount,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_result_code,
   output logic [7:0]         rsp_out_priority,
   output logic [3:0]         rsp_out_system_id,
   output logic [3:0]         rsp_out_resource_id,
   output logic [7:0]         rsp_out_status,
   output logic signed [15:0] rsp_out_amount,
   output logic [4:0]         rsp_occupancy
);

   speq_pkg::cmd_type    cmd;
   speq_pkg::status_type status;
   speq_pkg::event_type  req_event;
   speq_pkg::event_type  rsp_event;

   assign req_event.prio = req_priority_req;
   assign req_event.sys  = req_system_id;
   assign req_event.res  = req_resource_id;
   assign req_event.stat = req_event_status;
   assign req_event.amt  = req_amount;

   speq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_action),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .status     (status),
      .cmd        (cmd)
   );

   speq_dp #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_event     (req_event),
      .rsp_event     (rsp_event),
      .rsp_code      (rsp_result_code),
      .rsp_occupancy (rsp_occupancy)
   );

   assign rsp_out_priority    = rsp_event.prio;
   assign rsp_out_system_id   = rsp_event.sys;
   assign rsp_out_resource_id = rsp_event.res;
   assign rsp_out_status      = rsp_event.stat;
   assign rsp_out_amount      = rsp_event.amt;

   a_full_not_empty: assert property (@(posedge clock) disable iff (reset)
      !(status.full && status.empty))
      else $error("queue reports full and empty at once");

   a_accept_gives_word: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> rsp_valid)
      else $error("accepted request produced no result word");

   a_empty_pop_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_code == speq_pkg::RC_EMPTY)) |->
         (rsp_occupancy == 5'd0) && (rsp_out_priority == 8'd0))
      else $error("pop on empty queue returned data");

   a_never_both_cmds: assert property (@(posedge clock) disable iff (reset)
      !(cmd.push && cmd.pop))
      else $error("push and pop issued together");

endmodule

// ===== tb/tb_stable_priority_event_queue_core.sv =====
`timescale 1ns / 1ps

module tb_stable_priority_event_queue_core;

   localparam int DEPTH        = 16;
   localparam int RANDOM_ITEMS = 1200;
   localparam int PHASE_LEN    = 25;

   typedef struct packed {
      logic                action;
      speq_pkg::event_type ev;
   } request_type;

   typedef struct packed {
      logic [1:0]                 code;
      speq_pkg::event_type        ev;
      logic [speq_pkg::OCC_W-1:0] occ;
   } result_type;

   logic               clock               = 1'b0;
   logic               reset               = 1'b1;
   logic               req_valid           = 1'b0;
   logic               req_stall;
   logic               req_action          = speq_pkg::ACT_PUSH;
   logic [7:0]         req_priority_req    = '0;
   logic [3:0]         req_system_id       = '0;
   logic [3:0]         req_resource_id     = '0;
   logic [7:0]         req_event_status    = '0;
   logic signed [15:0] req_amount          = '0;
   logic               rsp_valid;
   logic               rsp_stall           = 1'b0;
   logic [1:0]         rsp_result_code;
   logic [7:0]         rsp_out_priority;
   logic [3:0]         rsp_out_system_id;
   logic [3:0]         rsp_out_resource_id;
   logic [7:0]         rsp_out_status;
   logic signed [15:0] rsp_out_amount;
   logic [4:0]         rsp_occupancy;

   request_type         pending_words[$];
   result_type          expected_results[$];
   speq_pkg::event_type model_events[$];

   int         errors    = 0;
   int         n_push    = 0;
   int         n_pop     = 0;
   int         n_full    = 0;
   int         n_empty   = 0;
   int         n_checked = 0;
   int         issued    = 0;
   logic [1:0] phase     = 2'd0;

   stable_priority_event_queue_core #(
      .QUEUE_DEPTH(DEPTH)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_action          (req_action),
      .req_priority_req    (req_priority_req),
      .req_system_id       (req_system_id),
      .req_resource_id     (req_resource_id),
      .req_event_status    (req_event_status),
      .req_amount          (req_amount),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_code     (rsp_result_code),
      .rsp_out_priority    (rsp_out_priority),
      .rsp_out_system_id   (rsp_out_system_id),
      .rsp_out_resource_id (rsp_out_resource_id),
      .rsp_out_status      (rsp_out_status),
      .rsp_out_amount      (rsp_out_amount),
      .rsp_occupancy       (rsp_occupancy)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int idle_pct(input logic [1:0] ph, input bit receiver);
      case (ph)
         2'd1: idle_pct = receiver ? 0 : 63;
         2'd2: idle_pct = receiver ? 63 : 0;
         2'd3: idle_pct = 6;
         default: idle_pct = 0;
      endcase
   endfunction

   function automatic request_type make_word(input logic act, input logic [7:0] p,
                                             input logic [3:0] s, input logic [3:0] r,
                                             input logic [7:0] st,
                                             input logic signed [15:0] a);
      make_word = '{action: act, ev: '{prio: p, sys: s, res: r, stat: st, amt: a}};
   endfunction

   // Priorities are drawn from narrow bands half the time so that ties are frequent.
   function automatic request_type random_word(input logic act);
      logic [7:0] p;
      case ($urandom_range(0, 3))
         0: p = 8'($urandom_range(0, 3));
         1: p = 8'($urandom_range(252, 255));
         default: p = 8'($urandom);
      endcase
      random_word = make_word(act, p, 4'($urandom), 4'($urandom), 8'($urandom),
                              16'($urandom));
   endfunction

   task automatic predict_queue_result(input request_type w);
      result_type r;
      int pos;
      r = '0;
      if (w.action == speq_pkg::ACT_PUSH) begin
         if (model_events.size() >= DEPTH) begin
            r.code = speq_pkg::RC_FULL;
            n_full++;
         end else begin
            pos = 0;
            while (pos < model_events.size() && model_events[pos].prio >= w.ev.prio)
               pos++;
            model_events.insert(pos, w.ev);
            r.code = speq_pkg::RC_OK;
            n_push++;
         end
      end else if (model_events.size() == 0) begin
         r.code = speq_pkg::RC_EMPTY;
         n_empty++;
      end else begin
         r.ev   = model_events.pop_front();
         r.code = speq_pkg::RC_OK;
         n_pop++;
      end
      r.occ = speq_pkg::OCC_W'(model_events.size());
      expected_results.push_back(r);
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin : driver
      request_type w;
      logic next_valid;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_queue_result({req_action, req_priority_req, req_system_id,
                                  req_resource_id, req_event_status, req_amount});
         end
         if (!req_valid || !req_stall) begin
            next_valid = 1'b0;
            if (pending_words.size() != 0 && $urandom_range(0, 99) >= idle_pct(phase, 0)) begin
               w = pending_words.pop_front();
               req_action       <= w.action;
               req_priority_req <= w.ev.prio;
               req_system_id    <= w.ev.sys;
               req_resource_id  <= w.ev.res;
               req_event_status <= w.ev.stat;
               req_amount       <= w.ev.amt;
               next_valid = 1'b1;
               issued <= issued + 1;
               phase  <= 2'(((issued + 1) / PHASE_LEN) % 4);
            end
            req_valid <= next_valid;
         end
      end
   end

   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t ns: result word with none expected, code %0d, occupancy %0d",
                        $time, rsp_result_code, rsp_occupancy);
               errors++;
            end else begin
               want = expected_results.pop_front();
               check_field("result_code", want.code, rsp_result_code);
               check_field("out_priority", want.ev.prio, rsp_out_priority);
               check_field("out_system_id", want.ev.sys, rsp_out_system_id);
               check_field("out_resource_id", want.ev.res, rsp_out_resource_id);
               check_field("out_status", want.ev.stat, rsp_out_status);
               check_field("out_amount", $signed(want.ev.amt), $signed(rsp_out_amount));
               check_field("occupancy", want.occ, rsp_occupancy);
               n_checked++;
            end
         end
         rsp_stall <= ($urandom_range(0, 99) < idle_pct(phase, 1));
      end
   end

   initial begin
      int count;
      int burst;
      int push_pct;

      // Empty pop, field extremes, equal priorities, fill to capacity, overflow, then five pops.
      pending_words.push_back(make_word(speq_pkg::ACT_POP, 8'd0, 4'd0, 4'd0, 8'd0, 16'sd0));
      pending_words.push_back(make_word(speq_pkg::ACT_PUSH, 8'd0, 4'd0, 4'd0, 8'd0, 16'sd0));
      pending_words.push_back(make_word(speq_pkg::ACT_PUSH, 8'd255, 4'd15, 4'd15, 8'd255,
                                        16'sd32767));
      pending_words.push_back(make_word(speq_pkg::ACT_PUSH, 8'd255, 4'd0, 4'd0, 8'd0,
                                        -16'sd32768));
      pending_words.push_back(make_word(speq_pkg::ACT_PUSH, 8'd128, 4'd5, 4'd10, 8'hA5,
                                        -16'sd1));
      pending_words.push_back(make_word(speq_pkg::ACT_PUSH, 8'd0, 4'd9, 4'd6, 8'h5A, 16'sd1));
      repeat (DEPTH - 5) pending_words.push_back(random_word(speq_pkg::ACT_PUSH));
      pending_words.push_back(random_word(speq_pkg::ACT_PUSH));
      repeat (5) pending_words.push_back(random_word(speq_pkg::ACT_POP));

      count = 0;
      while (count < RANDOM_ITEMS) begin
         burst = $urandom_range(8, 40);
         case ($urandom_range(0, 2))
            0: push_pct = 85;
            1: push_pct = 15;
            default: push_pct = 50;
         endcase
         repeat (burst) begin
            pending_words.push_back(random_word(($urandom_range(0, 99) < push_pct) ?
                                                speq_pkg::ACT_PUSH : speq_pkg::ACT_POP));
            count++;
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_valid) @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Covered %0d pushes, %0d pops, %0d pushes dropped when full, %0d empty pops,",
               n_push, n_pop, n_full, n_empty);
      $display("with %0d result words checked over four idling phases.", n_checked);
      if (errors == 0 && expected_results.size() == 0) begin
         $display("** stable_priority_event_queue_core: PASSED **");
      end else begin
         $display("** stable_priority_event_queue_core: FAILED **");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("%0t ns: run did not complete in time, %0d results outstanding",
               $time, expected_results.size());
      $display("** stable_priority_event_queue_core: FAILED **");
      $finish;
   end

endmodule
